>>> sv/bsps_pkg.sv
// ----------------------------------------------------------------------------
// bsps_pkg
// Shared widths, codes and control structs of the section path search block.
// ----------------------------------------------------------------------------
package bsps_pkg;

  localparam int SECTIONS_DEF      = 32;
  localparam int MAX_NEIGHBORS_DEF = 8;

  localparam int NODE_W  = 5;
  localparam int SLOT_W  = 3;
  localparam int TOTAL_W = 4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic query_ld;
    logic init;
    logic pop;
    logic cur_ld;
    logic scan;
    logic trace_push;
    logic walk_ld;
    logic emit_rd;
    logic emit_out;
    logic nopath_out;
  } bsps_cmd_t;

  typedef struct packed {
    logic query_bad;
    logic frontier_more;
    logic cur_is_goal;
    logic scan_done;
    logic walk_done;
    logic emit_last;
    logic out_free;
  } bsps_stat_t;

endpackage

>>> sv/bsps_if.sv
// ----------------------------------------------------------------------------
// bsps_in_if / bsps_out_if
// Valid/ready channels for load and query beats and for path result beats.
// ----------------------------------------------------------------------------
interface bsps_in_if import bsps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [NODE_W-1:0]  node_index;
  logic [SLOT_W-1:0]  slot_index;
  logic [NODE_W-1:0]  neighbor_node;
  logic [TOTAL_W-1:0] neighbor_total;
  logic [NODE_W-1:0]  start_node;
  logic [NODE_W-1:0]  goal_node;

  modport source (
    output valid, func, node_index, slot_index, neighbor_node, neighbor_total,
           start_node, goal_node,
    input  ready
  );
  modport sink (
    input  valid, func, node_index, slot_index, neighbor_node, neighbor_total,
           start_node, goal_node,
    output ready
  );
endinterface

interface bsps_out_if import bsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] path_node;
  logic              found;
  logic              last;

  modport source (output valid, path_node, found, last, input ready);
  modport sink   (input valid, path_node, found, last, output ready);
endinterface

>>> sv/bfs_section_path_search.sv
// ----------------------------------------------------------------------------
// bfs_section_path_search
// Breadth-first shortest path over a loaded neighbor table.
// ----------------------------------------------------------------------------
// A load beat (func 0) writes one neighbor slot and the node's neighbor count
// and returns nothing. A query beat (func 1) searches from start_node,
// expanding neighbors in stored order, then returns the path from start_node
// to goal_node one node per beat, with last set on the final beat; an
// unreachable goal returns a single beat with found cleared. The neighbor
// scan reads one table entry per cycle through the single read port of the
// neighbor table and covers at most SECTIONS*MAX_NEIGHBORS entries per query.
// Only one beat is worked on at a time; the next beat is accepted while the
// final result still waits in the output register.
// ----------------------------------------------------------------------------
module bfs_section_path_search import bsps_pkg::*; #(
  parameter int SECTIONS      = SECTIONS_DEF,
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  bsps_in_if.sink     in_if,
  bsps_out_if.source  out_if
);

  bsps_cmd_t  cmd;
  bsps_stat_t stat;
  logic       in_ready;

  assign in_if.ready = in_ready;

  bsps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bsps_dp #(
    .SECTIONS      (SECTIONS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .node_index     (in_if.node_index),
    .slot_index     (in_if.slot_index),
    .neighbor_node  (in_if.neighbor_node),
    .neighbor_total (in_if.neighbor_total),
    .start_node     (in_if.start_node),
    .goal_node      (in_if.goal_node),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_path_node  (out_if.path_node),
    .out_found      (out_if.found),
    .out_last       (out_if.last)
  );

endmodule

>>> sv/bsps_ctrl.sv
// ----------------------------------------------------------------------------
// bsps_ctrl
// Sequencer: table loads, search, parent trace and path output.
// ----------------------------------------------------------------------------
module bsps_ctrl import bsps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_func,
  output logic       in_ready,
  output bsps_cmd_t  cmd,
  input  bsps_stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_INIT   = 10'b00_0000_0010,
    S_POP    = 10'b00_0000_0100,
    S_CUR    = 10'b00_0000_1000,
    S_SCAN   = 10'b00_0001_0000,
    S_TPUSH  = 10'b00_0010_0000,
    S_TWAIT  = 10'b00_0100_0000,
    S_ERD    = 10'b00_1000_0000,
    S_EOUT   = 10'b01_0000_0000,
    S_NOPATH = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_wr  = accept && (in_func == FUNC_LOAD);
        cmd.query_ld = accept && (in_func == FUNC_QUERY);
        if (cmd.query_ld) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.query_bad) begin
          state_nxt = S_NOPATH;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stat.frontier_more) begin
          cmd.pop   = 1'b1;
          state_nxt = S_CUR;
        end else begin
          state_nxt = S_NOPATH;
        end
      end
      S_CUR: begin
        cmd.cur_ld = 1'b1;
        state_nxt  = stat.cur_is_goal ? S_TPUSH : S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_POP;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_TPUSH: begin
        cmd.trace_push = 1'b1;
        state_nxt      = stat.walk_done ? S_ERD : S_TWAIT;
      end
      S_TWAIT: begin
        cmd.walk_ld = 1'b1;
        state_nxt   = S_TPUSH;
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EOUT;
      end
      S_EOUT: begin
        if (stat.out_free) begin
          cmd.emit_out = 1'b1;
          state_nxt    = stat.emit_last ? S_IDLE : S_ERD;
        end
      end
      S_NOPATH: begin
        if (stat.out_free) begin
          cmd.nopath_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/bsps_dp.sv
// ----------------------------------------------------------------------------
// bsps_dp
// Datapath: neighbor table, degree store, seen marks, frontier queue,
// parent store, route stack and the output register.
// ----------------------------------------------------------------------------
module bsps_dp import bsps_pkg::*; #(
  parameter int SECTIONS      = SECTIONS_DEF,
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bsps_cmd_t          cmd,
  output bsps_stat_t         stat,
  input  logic [NODE_W-1:0]  node_index,
  input  logic [SLOT_W-1:0]  slot_index,
  input  logic [NODE_W-1:0]  neighbor_node,
  input  logic [TOTAL_W-1:0] neighbor_total,
  input  logic [NODE_W-1:0]  start_node,
  input  logic [NODE_W-1:0]  goal_node,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  out_path_node,
  output logic               out_found,
  output logic               out_last
);

  localparam int NW     = $clog2(SECTIONS);
  localparam int CW     = $clog2(SECTIONS + 1);
  localparam int DW     = $clog2(MAX_NEIGHBORS + 1);
  localparam int ADEPTH = SECTIONS * MAX_NEIGHBORS;
  localparam int AW     = (ADEPTH > 2) ? $clog2(ADEPTH) : 1;
  localparam logic [SECTIONS-1:0] SEEN_ONE = SECTIONS'(1);

  // storage
  logic [NODE_W-1:0] adj_mem [ADEPTH];
  logic [DW-1:0]     deg_mem [SECTIONS];
  logic [NW-1:0]     fr_mem  [SECTIONS];
  logic [NW-1:0]     par_mem [SECTIONS];
  logic [NW-1:0]     stk_mem [SECTIONS];

  logic [SECTIONS-1:0] deg_vld_r;
  logic [SECTIONS-1:0] seen_r;

  logic [NODE_W-1:0] adj_rd_r;
  logic [DW-1:0]     deg_rd_r;
  logic              deg_vrd_r;
  logic [NW-1:0]     fr_rd_r;
  logic [NW-1:0]     par_rd_r;
  logic [NW-1:0]     stk_rd_r;

  logic [NODE_W-1:0] start_r, goal_r;
  logic [NW-1:0]     cur_r, walk_r;
  logic [DW-1:0]     n_r;
  logic [CW-1:0]     head_r, tail_r, depth_r, idx_r;

  logic              out_valid_r, out_found_r, out_last_r;
  logic [NODE_W-1:0] out_path_r;

  logic          load_ok, slot_ok;
  logic [AW-1:0] adj_waddr, adj_raddr;
  logic [DW-1:0] tot_sat, cnt;
  logic [NW-1:0] ld_idx, sidx, gidx, nb_idx;
  logic          nb_in, enq;
  logic [CW-1:0] idx_m1;

  assign load_ok   = int'(node_index) < SECTIONS;
  assign slot_ok   = int'(slot_index) < MAX_NEIGHBORS;
  assign adj_waddr = AW'(int'(node_index) * MAX_NEIGHBORS + int'(slot_index));
  assign tot_sat   = (int'(neighbor_total) > MAX_NEIGHBORS) ? DW'(MAX_NEIGHBORS)
                                                           : DW'(neighbor_total);
  assign ld_idx    = NW'(node_index);
  assign sidx      = NW'(start_r);
  assign gidx      = NW'(goal_r);

  assign adj_raddr = cmd.cur_ld ? AW'(int'(fr_rd_r) * MAX_NEIGHBORS)
                                : AW'(int'(cur_r) * MAX_NEIGHBORS + int'(n_r) + 1);

  assign cnt    = deg_vrd_r ? deg_rd_r : '0;
  assign nb_idx = NW'(adj_rd_r);
  assign nb_in  = int'(adj_rd_r) < SECTIONS;
  assign enq    = nb_in && !seen_r[nb_idx] && (int'(tail_r) < SECTIONS);
  assign idx_m1 = idx_r - CW'(1);

  assign stat.query_bad     = (int'(start_r) >= SECTIONS) || (int'(goal_r) >= SECTIONS);
  assign stat.frontier_more = head_r < tail_r;
  assign stat.cur_is_goal   = fr_rd_r == gidx;
  assign stat.scan_done     = n_r >= cnt;
  assign stat.walk_done     = (walk_r == sidx) || (int'(depth_r) + 1 == SECTIONS);
  assign stat.emit_last     = idx_r == CW'(1);
  assign stat.out_free      = !out_valid_r || out_ready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok && slot_ok) begin
      adj_mem[adj_waddr] <= neighbor_node;
    end
    adj_rd_r <= adj_mem[adj_raddr];

    if (cmd.load_wr && load_ok) begin
      deg_mem[ld_idx] <= tot_sat;
    end
    if (cmd.cur_ld) begin
      deg_rd_r  <= deg_mem[fr_rd_r];
      deg_vrd_r <= deg_vld_r[fr_rd_r];
    end

    if (cmd.init) begin
      fr_mem[0]     <= sidx;
      par_mem[sidx] <= sidx;
    end else if (cmd.scan && enq) begin
      fr_mem[tail_r[NW-1:0]] <= nb_idx;
      par_mem[nb_idx]        <= cur_r;
    end
    if (cmd.pop) begin
      fr_rd_r <= fr_mem[head_r[NW-1:0]];
    end
    if (cmd.trace_push) begin
      par_rd_r                 <= par_mem[walk_r];
      stk_mem[depth_r[NW-1:0]] <= walk_r;
    end
    if (cmd.emit_rd) begin
      stk_rd_r <= stk_mem[idx_m1[NW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.query_ld) begin
      start_r <= start_node;
      goal_r  <= goal_node;
    end
    if (cmd.cur_ld) begin
      cur_r  <= fr_rd_r;
      walk_r <= gidx;
    end else if (cmd.walk_ld) begin
      walk_r <= par_rd_r;
    end
    if (cmd.emit_out) begin
      out_path_r  <= NODE_W'(stk_rd_r);
      out_found_r <= 1'b1;
      out_last_r  <= stat.emit_last;
    end else if (cmd.nopath_out) begin
      out_path_r  <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_vld_r   <= '0;
      seen_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      n_r         <= '0;
      depth_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_wr && load_ok) begin
        deg_vld_r[ld_idx] <= 1'b1;
      end

      if (cmd.init) begin
        seen_r <= SEEN_ONE << sidx;
        head_r <= '0;
        tail_r <= CW'(1);
      end else begin
        if (cmd.scan && enq) begin
          seen_r[nb_idx] <= 1'b1;
          tail_r         <= tail_r + CW'(1);
        end
        if (cmd.pop) begin
          head_r <= head_r + CW'(1);
        end
      end

      if (cmd.cur_ld) begin
        n_r     <= '0;
        depth_r <= '0;
      end else if (cmd.scan) begin
        n_r <= n_r + DW'(1);
      end else if (cmd.trace_push) begin
        depth_r <= depth_r + CW'(1);
      end

      if (cmd.trace_push) begin
        idx_r <= depth_r + CW'(1);
      end else if (cmd.emit_out) begin
        idx_r <= idx_m1;
      end

      if (cmd.emit_out || cmd.nopath_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_node = out_path_r;
  assign out_found     = out_found_r;
  assign out_last      = out_last_r;

endmodule

>>> sim/tb_bfs_section_path_search.sv
// ----------------------------------------------------------------------------
// tb_bfs_section_path_search
// Self-checking bench for the breadth-first section path search block.
// ----------------------------------------------------------------------------
// Load beats build neighbor lists, and query beats ask for a start-to-goal
// route. A local shortest-path predictor tracks the neighbor table. On each
// accepted query it queues the expected route beats, and a checker compares
// every result beat against that queue. Neighbor counts never reach past the
// slots that have been written. The sequence is: directed cases, then a long
// hold-off on the result side, then random graphs and chains with idle bursts
// on both sides, and a final stretch without idling.
// ----------------------------------------------------------------------------
module tb_bfs_section_path_search import bsps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES        = SECTIONS_DEF;
  localparam int SLOTS        = MAX_NEIGHBORS_DEF;
  localparam int TOTAL_MAX    = (1 << TOTAL_W) - 1;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 500;
  localparam int LONG_HOLD    = 500;

  typedef struct packed {
    logic               func;
    logic [NODE_W-1:0]  node_index;
    logic [SLOT_W-1:0]  slot_index;
    logic [NODE_W-1:0]  neighbor_node;
    logic [TOTAL_W-1:0] neighbor_total;
    logic [NODE_W-1:0]  start_node;
    logic [NODE_W-1:0]  goal_node;
  } beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic              found;
    logic              last;
  } hop_t;

  logic clk;
  logic rst_n;

  bsps_in_if  in_ch();
  bsps_out_if out_ch();

  bfs_section_path_search i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  int   nbr_table   [NODES][SLOTS];
  int   nbr_count   [NODES];
  bit   slot_loaded [NODES][SLOTS];
  hop_t route_q[$];

  bit idle_on = 1'b1;
  int long_hold_req = 0;
  int hold_left = 0;
  int beats_sent = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int no_path_seen = 0;
  int hops_seen = 0;
  int long_holds = 0;
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // highest legal count for a load: never past the written prefix
  function automatic int top_total(int node, int slot);
    int run;
    run = 0;
    while (run < SLOTS && (slot_loaded[node][run] || run == slot)) run++;
    return (run == SLOTS) ? TOTAL_MAX : run;
  endfunction

  function automatic beat_t load_beat(int node, int slot, int nb, int total);
    beat_t b;
    b.func           = FUNC_LOAD;
    b.node_index     = NODE_W'(node);
    b.slot_index     = SLOT_W'(slot);
    b.neighbor_node  = NODE_W'(nb);
    b.neighbor_total = TOTAL_W'(total);
    b.start_node     = NODE_W'($urandom);
    b.goal_node      = NODE_W'($urandom);
    return b;
  endfunction

  function automatic beat_t query_beat(int start, int goal);
    beat_t b;
    b.func           = FUNC_QUERY;
    b.node_index     = NODE_W'($urandom);
    b.slot_index     = SLOT_W'($urandom);
    b.neighbor_node  = NODE_W'($urandom);
    b.neighbor_total = TOTAL_W'($urandom);
    b.start_node     = NODE_W'(start);
    b.goal_node      = NODE_W'(goal);
    return b;
  endfunction

  function automatic void store_neighbor(beat_t b);
    nbr_table[b.node_index][b.slot_index]   = int'(b.neighbor_node);
    slot_loaded[b.node_index][b.slot_index] = 1'b1;
    nbr_count[b.node_index] = (int'(b.neighbor_total) > SLOTS) ? SLOTS
                                                               : int'(b.neighbor_total);
  endfunction

  function automatic void predict_route(int start, int goal);
    bit   reached [NODES];
    int   via [NODES];
    int   ring [NODES];
    int   head, tail, cur, nb;
    bit   hit;
    int   trail[$];
    hop_t hop;
    head = 0;
    tail = 1;
    hit  = 1'b0;
    ring[0] = start;
    reached[start] = 1'b1;
    via[start] = start;
    while (head < tail && !hit) begin
      cur = ring[head];
      head++;
      if (cur == goal) begin
        hit = 1'b1;
      end else begin
        for (int n = 0; n < nbr_count[cur]; n++) begin
          nb = nbr_table[cur][n];
          if (!reached[nb]) begin
            reached[nb] = 1'b1;
            via[nb] = cur;
            ring[tail] = nb;
            tail++;
          end
        end
      end
    end
    if (!hit) begin
      hop.path_node = '0;
      hop.found     = 1'b0;
      hop.last      = 1'b1;
      route_q.push_back(hop);
      no_path_seen++;
      return;
    end
    cur = goal;
    trail.push_front(cur);
    while (cur != start) begin
      cur = via[cur];
      trail.push_front(cur);
    end
    foreach (trail[i]) begin
      hop.path_node = NODE_W'(trail[i]);
      hop.found     = 1'b1;
      hop.last      = (i == trail.size() - 1);
      route_q.push_back(hop);
    end
  endfunction

  task automatic send_beat(input beat_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= b.func;
    in_ch.node_index     <= b.node_index;
    in_ch.slot_index     <= b.slot_index;
    in_ch.neighbor_node  <= b.neighbor_node;
    in_ch.neighbor_total <= b.neighbor_total;
    in_ch.start_node     <= b.start_node;
    in_ch.goal_node      <= b.goal_node;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (b.func == FUNC_LOAD) begin
      loads_sent++;
      store_neighbor(b);
    end else begin
      queries_sent++;
      predict_route(int'(b.start_node), int'(b.goal_node));
    end
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : hop_sink
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req > 0) begin
        hold_left = long_hold_req - 1;
        long_hold_req = 0;
        long_holds++;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_hops
    hop_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      hops_seen++;
      if (route_q.size() == 0) begin
        $error("unexpected result beat: path_node %0d found %0d last %0d",
               out_ch.path_node, out_ch.found, out_ch.last);
        errors++;
      end else begin
        want = route_q.pop_front();
        if (out_ch.path_node !== want.path_node) begin
          $error("path_node: expected %0d, got %0d", want.path_node, out_ch.path_node);
          errors++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_ch.found);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_beat(query_beat(NODES - 1, NODES - 1));  // start is goal, empty table
    send_beat(query_beat(0, NODES - 1));          // no neighbors anywhere
    send_beat(load_beat(0, 0, NODES - 1, 1));
    send_beat(query_beat(0, NODES - 1));
    for (int s = 0; s < SLOTS - 1; s++) begin
      send_beat(load_beat(NODES - 1, s, (s == SLOTS - 2) ? NODES - 1 : 0, s + 1));
    end
    send_beat(load_beat(NODES - 1, SLOTS - 1, 9, TOTAL_MAX));  // count saturates
    send_beat(query_beat(0, 9));
    // two equal-length routes: stored order picks the parent
    send_beat(load_beat(1, 0, 2, 1));
    send_beat(load_beat(1, 1, 3, 2));
    send_beat(load_beat(2, 0, 4, 1));
    send_beat(load_beat(3, 0, 4, 1));
    send_beat(query_beat(1, 4));
    send_beat(load_beat(1, 0, 3, 2));
    send_beat(query_beat(1, 4));
    send_beat(load_beat(3, 0, 4, 0));
    send_beat(query_beat(1, 4));
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    send_beat(load_beat(3, 0, 4, 1));
    long_hold_req = LONG_HOLD;
    repeat (2) begin
      send_beat(query_beat(1, 4));
      send_beat(query_beat(0, 9));
      send_beat(query_beat(0, NODES - 1));
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_graphs(input int target, input bit allow_idle);
    int order [NODES];
    int first, m, d, pick, tmp, node, slot, total, a, b;
    bit chain;
    first = beats_sent;
    while (beats_sent - first < target) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      foreach (order[i]) order[i] = i;
      for (int i = NODES - 1; i > 0; i--) begin
        pick = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[pick];
        order[pick] = tmp;
      end
      chain = ($urandom_range(0, 2) == 0);
      m = chain ? $urandom_range(6, NODES) : $urandom_range(3, 12);
      for (int k = 0; k < m; k++) begin
        node = order[k];
        if (chain) d = (k == m - 1) ? $urandom_range(0, 1) : $urandom_range(1, 2);
        else d = ($urandom_range(0, 7) == 0) ? SLOTS : $urandom_range(0, 4);
        if (d == 0) send_beat(load_beat(node, $urandom_range(0, SLOTS - 1), $urandom, 0));
        for (int s = 0; s < d; s++) begin
          if (chain && s == 0 && k < m - 1) pick = order[k + 1];
          else if (chain) pick = order[$urandom_range(0, k)];
          else if ($urandom_range(0, 5) == 0) pick = $urandom_range(0, NODES - 1);
          else pick = order[$urandom_range(0, m - 1)];
          total = (d == SLOTS && s == SLOTS - 1) ? $urandom_range(SLOTS, TOTAL_MAX) : s + 1;
          send_beat(load_beat(node, s, pick, total));
        end
      end
      // stray loads anywhere in the table
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0) begin
        node = $urandom_range(0, NODES - 1);
        slot = $urandom_range(0, SLOTS - 1);
        send_beat(load_beat(node, slot, $urandom, $urandom_range(0, top_total(node, slot))));
      end
      repeat ($urandom_range(3, 8)) begin
        if (chain && $urandom_range(0, 1) == 0) begin
          a = order[$urandom_range(0, 2)];
          b = order[m - 1 - $urandom_range(0, 2)];
        end else begin
          a = ($urandom_range(0, 5) == 0) ? $urandom_range(0, NODES - 1)
                                          : order[$urandom_range(0, m - 1)];
          b = ($urandom_range(0, 5) == 0) ? $urandom_range(0, NODES - 1)
                                          : order[$urandom_range(0, m - 1)];
          if ($urandom_range(0, 9) == 0) b = a;
        end
        send_beat(query_beat(a, b));
      end
    end
  endtask

  initial begin : stimulus
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_LOAD;
    in_ch.node_index     = '0;
    in_ch.slot_index     = '0;
    in_ch.neighbor_node  = '0;
    in_ch.neighbor_total = '0;
    in_ch.start_node     = '0;
    in_ch.goal_node      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_output_hold();
    test_random_graphs(160, 1'b1);
    test_random_graphs(40, 1'b0);  // closing stretch, no idling
    in_ch.valid <= 1'b0;

    while (route_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d loads, %0d queries (%0d with no route).",
             beats_sent, loads_sent, queries_sent, no_path_seen);
    $display("Checked %0d result beats; %0d long result hold-off(s); %0d mismatch(es).",
             hops_seen, long_holds, errors);
    if (errors == 0 && route_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/bsps_pkg.sv
sv/bsps_if.sv
sv/bsps_ctrl.sv
sv/bsps_dp.sv
sv/bfs_section_path_search.sv
sim/tb_bfs_section_path_search.sv
